[src/fwdf_pkg.sv]
// shared types and constants of the fixed-width decimal formatter
// no dependencies; imported by the controller, the datapath and the top level
package fwdf_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMAL_PLACES = 1'd1;

  localparam int FW_W = 5;
  localparam int DP_W = 4;
  localparam logic [FW_W-1:0] FIELD_WIDTH_RST    = 5'd8;
  localparam logic [DP_W-1:0] DECIMAL_PLACES_RST = 4'd2;

  // number of entries in the rounding bias table, one per place count
  localparam int NUM_PLACES = 1 << DP_W;

  // ascii codes, low six bits
  localparam int CHAR_W = 6;
  localparam logic [CHAR_W-1:0] CH_SPACE = 6'd32;
  localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CH_POINT = 6'd46;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CH_NINE  = 6'd57;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_CONV,
    ST_EMIT
  } fwdf_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic prep;
    logic step;
    logic emit;
  } fwdf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic conv_last;
    logic pos_last;
    logic out_free;
  } fwdf_sts_t;

  // elaboration-time power of ten
  function automatic longint unsigned pow10(int n);
    longint unsigned p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

endpackage

[src/fwdf_ctrl.sv]
// sequencing state machine of the fixed-width decimal formatter
// depends on fwdf_pkg; drives the datapath by command bits, reads its status
module fwdf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output fwdf_pkg::fwdf_cmd_t   cmd,
  input  fwdf_pkg::fwdf_sts_t   sts
);
  import fwdf_pkg::*;

  fwdf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (sts.conv_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free && sts.pos_last) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
      end
      ST_CONV: begin
        cmd.step = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[src/fwdf_dpath.sv]
// datapath: sign and magnitude, rounding bias, serial binary-to-bcd conversion,
// fraction digit generation and the output word register; depends on fwdf_pkg
module fwdf_dpath #(
  parameter int MAX_WIDTH     = 16,
  parameter int FRACTION_BITS = 24,
  parameter int INTEGER_BITS  = 24
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic [fwdf_pkg::FW_W-1:0]                field_width,
  input  logic [fwdf_pkg::DP_W-1:0]                decimal_places,
  input  logic [INTEGER_BITS+FRACTION_BITS-1:0]    in_value,
  input  fwdf_pkg::fwdf_cmd_t                      cmd,
  output fwdf_pkg::fwdf_sts_t                      sts,
  input  logic                                     out_ready,
  output logic                                     out_valid,
  output logic [fwdf_pkg::CHAR_W-1:0]              out_char_code,
  output logic [$clog2(MAX_WIDTH)-1:0]             out_position,
  output logic                                     out_last
);
  import fwdf_pkg::*;

  localparam int VB  = INTEGER_BITS + FRACTION_BITS;
  localparam int FB  = FRACTION_BITS;
  localparam int IB  = INTEGER_BITS;
  localparam int PW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int CW  = ((WW > DP_W) ? WW : DP_W) + 1;
  localparam int ND  = (IB * 30103) / 100000 + 1;
  localparam int NDW = $clog2(ND + 1);
  localparam int KW  = (WW > NDW) ? WW : NDW;
  localparam int CNW = $clog2(IB);

  // rounding bias table: 0.4 units of the last place
  logic [FB-1:0] bias_tbl [NUM_PLACES];

  genvar gp;
  generate
    for (gp = 0; gp < NUM_PLACES; gp++) begin : g_bias
      localparam longint unsigned P10 = pow10(gp + 1);
      localparam longint unsigned BV  = ((64'd4 << FB) + P10 / 2) / P10;
      assign bias_tbl[gp] = BV[FB-1:0];
    end
  endgenerate

  logic                neg_r;
  logic [VB-1:0]       mag_r;
  logic [WW-1:0]       mid_r;
  logic [PW-1:0]       wlast_r;
  logic [DP_W-1:0]     pl_r;
  logic [IB-1:0]       bin_r;
  logic [ND*4-1:0]     bcd_r;
  logic [FB-1:0]       frac_r;
  logic [CNW-1:0]      cnt_r;
  logic [PW-1:0]       pos_r;
  logic                out_valid_r;
  logic [CHAR_W-1:0]   char_r;
  logic [PW-1:0]       opos_r;
  logic                olast_r;

  // capture: sign, magnitude, field geometry
  logic                neg_c;
  logic [VB-1:0]       mag_c;
  logic [CW-1:0]       w_c;
  logic [CW-1:0]       dp_c;
  logic [CW-1:0]       ng_c;
  logic [CW-1:0]       mid_c;
  logic [CW-1:0]       pl_c;

  always_comb begin
    neg_c = in_value[VB-1];
    mag_c = neg_c ? (~in_value + VB'(1)) : in_value;
    if (field_width == '0) begin
      w_c = CW'(1);
    end else if (int'(field_width) > MAX_WIDTH) begin
      w_c = CW'(MAX_WIDTH);
    end else begin
      w_c = CW'(field_width);
    end
    dp_c = CW'(decimal_places);
    ng_c = CW'(neg_c);
    if (decimal_places == '0) begin
      mid_c = w_c;
      pl_c  = '0;
    end else if (dp_c + ng_c + CW'(1) > w_c) begin
      mid_c = ng_c;
      pl_c  = (w_c > ng_c + CW'(1)) ? (w_c - ng_c - CW'(1)) : '0;
    end else begin
      mid_c = w_c - dp_c - CW'(1);
      pl_c  = dp_c;
    end
  end

  // biased magnitude, cannot overflow since the magnitude is at most half range
  logic [VB-1:0] m_sum;
  assign m_sum = mag_r + VB'(bias_tbl[pl_r]);

  // double-dabble adjust
  logic [ND*4-1:0] bcd_adj;
  always_comb begin
    for (int j = 0; j < ND; j++) begin
      bcd_adj[4*j +: 4] = (bcd_r[4*j +: 4] >= 4'd5) ? (bcd_r[4*j +: 4] + 4'd3)
                                                    : bcd_r[4*j +: 4];
    end
  end

  // significant integer digits, at least one
  logic [NDW-1:0] nd;
  always_comb begin
    nd = NDW'(1);
    for (int j = 1; j < ND; j++) begin
      if (bcd_r[4*j +: 4] != 4'd0) nd = NDW'(j + 1);
    end
  end

  // character for the current position
  logic [WW-1:0]     pos_x;
  logic [WW-1:0]     k;
  logic [KW-1:0]     k_x;
  logic [3:0]        dsel;
  logic              digit_ok;
  logic              lead;
  logic [FB+3:0]     frac_x10;
  logic [CHAR_W-1:0] char_c;

  always_comb begin
    pos_x    = WW'(pos_r);
    k        = mid_r - WW'(1) - pos_x;
    k_x      = KW'(k);
    digit_ok = k_x < KW'(nd);
    lead     = (k_x == KW'(nd)) || ((pos_x == '0) && digit_ok);
    dsel     = 4'd0;
    for (int j = 0; j < ND; j++) begin
      if (k_x == KW'(j)) dsel = bcd_r[4*j +: 4];
    end
    frac_x10 = ({4'b0000, frac_r} << 3) + ({4'b0000, frac_r} << 1);
    if (pos_x == mid_r) begin
      char_c = CH_POINT;
    end else if (pos_x > mid_r) begin
      char_c = CH_ZERO + CHAR_W'(frac_x10[FB+3:FB]);
    end else if ((pos_x != '0) && digit_ok) begin
      char_c = CH_ZERO + CHAR_W'(dsel);
    end else if (lead) begin
      if (neg_r) begin
        char_c = CH_MINUS;
      end else if (digit_ok) begin
        char_c = CH_ZERO + CHAR_W'(dsel);
      end else begin
        char_c = CH_SPACE;
      end
    end else begin
      char_c = CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      neg_r   <= neg_c;
      mag_r   <= mag_c;
      mid_r   <= WW'(mid_c);
      wlast_r <= PW'(w_c - CW'(1));
      pl_r    <= DP_W'(pl_c);
    end
    if (cmd.prep) begin
      bin_r  <= m_sum[VB-1:FB];
      frac_r <= m_sum[FB-1:0];
      bcd_r  <= '0;
      cnt_r  <= '0;
      pos_r  <= '0;
    end
    if (cmd.step) begin
      bcd_r <= {bcd_adj[ND*4-2:0], bin_r[IB-1]};
      bin_r <= {bin_r[IB-2:0], 1'b0};
      cnt_r <= cnt_r + CNW'(1);
    end
    if (cmd.emit) begin
      char_r  <= char_c;
      opos_r  <= pos_r;
      olast_r <= (pos_r == wlast_r);
      pos_r   <= pos_r + PW'(1);
      if (pos_x > mid_r) frac_r <= frac_x10[FB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.conv_last = (cnt_r == CNW'(IB - 1));
  assign sts.pos_last  = (pos_r == wlast_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_char_code = char_r;
  assign out_position  = opos_r;
  assign out_last      = olast_r;

  // a word is only loaded into a free output slot
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit && out_valid_r && !out_ready))
    else $error("word loaded over a pending word");

  // converted integer digits are valid bcd
  a_bcd_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && (pos_x < mid_r) && digit_ok) |-> (dsel <= 4'd9))
    else $error("integer digit out of bcd range");

  // the point never lies beyond the field's right edge plus one
  a_mid_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (mid_r <= WW'(wlast_r) + WW'(1)))
    else $error("point position beyond field");

  // every emitted character code lies between space and nine
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> ((char_c >= CH_SPACE) && (char_c <= CH_NINE)))
    else $error("character code out of range");

endmodule

[src/fixed_width_decimal_formatter_core.sv]
// top level of the fixed-width decimal formatter
// depends on fwdf_pkg, fwdf_ctrl and fwdf_dpath; holds the configuration registers
//
// Formats one signed fixed-point value (INTEGER_BITS.FRACTION_BITS, two's
// complement) into a right-aligned ASCII field of field_width characters and
// sends it out one word per character, from position 0 upward, with last set
// on the rightmost one. Each value is captured, gets the rounding bias added,
// passes bit-serially through the binary-to-bcd converter and then leaves one
// character at a time through the single output register, which holds a word
// until out_ready takes it. in_ready is high only between values; the last
// character may still wait in the output register while the next value is
// taken. field_width 0 acts as 1 and widths above MAX_WIDTH act as MAX_WIDTH.
// Change the configuration only while no value is in flight.
module fixed_width_decimal_formatter_core #(
  parameter int MAX_WIDTH     = 16,
  parameter int FRACTION_BITS = 24,
  parameter int INTEGER_BITS  = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration write port
  input  logic                                   cfg_we,
  input  logic [fwdf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [fwdf_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  // input words
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [INTEGER_BITS+FRACTION_BITS-1:0]  in_value,
  // result words, one per character
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [fwdf_pkg::CHAR_W-1:0]            out_char_code,
  output logic [$clog2(MAX_WIDTH)-1:0]           out_position,
  output logic                                   out_last
);
  import fwdf_pkg::*;

  // configuration registers
  logic [FW_W-1:0] field_width_r;
  logic [DP_W-1:0] decimal_places_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_width_r    <= FIELD_WIDTH_RST;
      decimal_places_r <= DECIMAL_PLACES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIELD_WIDTH: begin
          field_width_r <= cfg_wdata[FW_W-1:0];
        end
        REG_DECIMAL_PLACES: begin
          decimal_places_r <= cfg_wdata[DP_W-1:0];
        end
        default: begin
          field_width_r <= field_width_r;
        end
      endcase
    end
  end

  fwdf_cmd_t cmd;
  fwdf_sts_t sts;

  // sequencer: idle, bias add, conversion, character output
  fwdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // arithmetic and character selection, plus the output word register
  fwdf_dpath #(
    .MAX_WIDTH     (MAX_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .INTEGER_BITS  (INTEGER_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .field_width    (field_width_r),
    .decimal_places (decimal_places_r),
    .in_value       (in_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_char_code  (out_char_code),
    .out_position   (out_position),
    .out_last       (out_last)
  );

endmodule
